// File: src/iecr_pkg.sv
// shared types and constants for the icmp echo reply classifier
package iecr_pkg;

   // verdict codes
   localparam logic [1:0] VERDICT_SHORT     = 2'd0;
   localparam logic [1:0] VERDICT_REPLY     = 2'd1;
   localparam logic [1:0] VERDICT_ERROR     = 2'd2;
   localparam logic [1:0] VERDICT_UNRELATED = 2'd3;

   // register indexes on the csr port
   localparam logic [1:0] CSR_EXPECTED_IDENT = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_SEQ   = 2'd1;
   localparam logic [1:0] CSR_TARGET_ADDR    = 2'd2;

   // outer ip header offsets
   localparam logic [15:0] POS_VER_IHL = 16'd0;
   localparam logic [15:0] POS_TTL     = 16'd8;

   // offsets relative to the start of the icmp message
   localparam logic [15:0] REL_TYPE      = 16'd0;
   localparam logic [15:0] REL_CODE      = 16'd1;
   localparam logic [15:0] REL_REST_0    = 16'd4;
   localparam logic [15:0] REL_REST_1    = 16'd5;
   localparam logic [15:0] REL_REST_2    = 16'd6;
   localparam logic [15:0] REL_REST_3    = 16'd7;
   localparam logic [15:0] REL_IN_PROTO  = 16'd17;
   localparam logic [15:0] REL_IN_DST_0  = 16'd24;
   localparam logic [15:0] REL_IN_DST_1  = 16'd25;
   localparam logic [15:0] REL_IN_DST_2  = 16'd26;
   localparam logic [15:0] REL_IN_DST_3  = 16'd27;
   localparam logic [15:0] REL_IN_TYPE   = 16'd28;
   localparam logic [15:0] REL_IN_IDENT0 = 16'd32;
   localparam logic [15:0] REL_IN_IDENT1 = 16'd33;

   // minimum lengths past the ip header
   localparam logic [16:0] ICMP_MIN = 17'd8;
   localparam logic [16:0] ERR_MIN  = 17'd34;

   // protocol and message types
   localparam logic [7:0] PROTO_ICMP      = 8'd1;
   localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
   localparam logic [7:0] TYPE_ECHO_REQ   = 8'd8;

   // per-packet capture state
   typedef struct packed {
      logic [15:0] byte_count;
      logic [5:0]  ip_header_len;
      logic [7:0]  outer_ttl;
      logic [7:0]  type_seen;
      logic [7:0]  code_seen;
      logic [31:0] rest_word;
      logic [31:0] inner_dst;
      logic [7:0]  inner_proto;
      logic [7:0]  inner_type;
      logic [15:0] inner_ident;
   } snap_type;

   // configuration registers
   typedef struct packed {
      logic [15:0] expected_ident;
      logic [15:0] expected_seq;
      logic [31:0] target_addr;
   } cfg_type;

   // one result
   typedef struct packed {
      logic [1:0]  verdict;
      logic [7:0]  return_ttl;
      logic [15:0] icmp_length;
      logic [7:0]  msg_type;
      logic [7:0]  msg_code;
      logic [31:0] header_rest;
   } result_type;

endpackage

// File: src/iecr_capture.sv
// per-packet field capture: byte counter and header field registers
module iecr_capture #(
   parameter int MAX_PACKET = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        data_in,
   input  logic              last_in,
   output iecr_pkg::snap_type snap
);

   iecr_pkg::snap_type snap_ff;
   iecr_pkg::snap_type snap_in;

   logic [15:0] pos;
   logic [5:0]  hlen;
   logic [15:0] rel;

   always_comb begin
      snap_in = snap_ff;
      pos     = snap_ff.byte_count;
      hlen    = (pos == iecr_pkg::POS_VER_IHL) ? {data_in[3:0], 2'b00} : snap_ff.ip_header_len;
      rel     = pos - {10'd0, hlen};
      if (pos < 16'(MAX_PACKET)) begin
         snap_in.byte_count    = pos + 16'd1;
         snap_in.ip_header_len = hlen;
         if (pos == iecr_pkg::POS_TTL) begin
            snap_in.outer_ttl = data_in;
         end
         if (pos >= {10'd0, hlen}) begin
            case (rel)
               iecr_pkg::REL_TYPE:      snap_in.type_seen           = data_in;
               iecr_pkg::REL_CODE:      snap_in.code_seen           = data_in;
               iecr_pkg::REL_REST_0:    snap_in.rest_word[31:24]    = data_in;
               iecr_pkg::REL_REST_1:    snap_in.rest_word[23:16]    = data_in;
               iecr_pkg::REL_REST_2:    snap_in.rest_word[15:8]     = data_in;
               iecr_pkg::REL_REST_3:    snap_in.rest_word[7:0]      = data_in;
               iecr_pkg::REL_IN_PROTO:  snap_in.inner_proto         = data_in;
               iecr_pkg::REL_IN_DST_0:  snap_in.inner_dst[31:24]    = data_in;
               iecr_pkg::REL_IN_DST_1:  snap_in.inner_dst[23:16]    = data_in;
               iecr_pkg::REL_IN_DST_2:  snap_in.inner_dst[15:8]     = data_in;
               iecr_pkg::REL_IN_DST_3:  snap_in.inner_dst[7:0]      = data_in;
               iecr_pkg::REL_IN_TYPE:   snap_in.inner_type          = data_in;
               iecr_pkg::REL_IN_IDENT0: snap_in.inner_ident[15:8]   = data_in;
               iecr_pkg::REL_IN_IDENT1: snap_in.inner_ident[7:0]    = data_in;
               default: ;
            endcase
         end
      end
   end

   // fields as they stand once this byte is taken in
   assign snap = snap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= '0;
      end else if (step) begin
         snap_ff <= last_in ? '0 : snap_in;
      end
   end

endmodule

// File: src/iecr_classify.sv
// verdict and result fields from the captured packet fields
module iecr_classify (
   input  iecr_pkg::snap_type   snap,
   input  iecr_pkg::cfg_type    cfg,
   output iecr_pkg::result_type result
);

   logic [16:0] cc;
   logic [16:0] hl;
   logic        reply_match;
   logic        error_match;

   assign cc = {1'b0, snap.byte_count};
   assign hl = {11'd0, snap.ip_header_len};

   assign reply_match = (snap.rest_word[31:16] == cfg.expected_ident) &&
                        (snap.rest_word[15:0] == cfg.expected_seq);
   assign error_match = (snap.inner_dst == cfg.target_addr) &&
                        (snap.inner_proto == iecr_pkg::PROTO_ICMP) &&
                        (snap.inner_type == iecr_pkg::TYPE_ECHO_REQ) &&
                        (snap.inner_ident == cfg.expected_ident);

   always_comb begin
      if (cc < hl + iecr_pkg::ICMP_MIN) begin
         result.verdict = iecr_pkg::VERDICT_SHORT;
      end else if (snap.type_seen == iecr_pkg::TYPE_ECHO_REPLY) begin
         result.verdict = reply_match ? iecr_pkg::VERDICT_REPLY : iecr_pkg::VERDICT_UNRELATED;
      end else if (cc < hl + iecr_pkg::ERR_MIN) begin
         // error too short to hold the inner headers
         result.verdict = iecr_pkg::VERDICT_UNRELATED;
      end else begin
         result.verdict = error_match ? iecr_pkg::VERDICT_ERROR : iecr_pkg::VERDICT_UNRELATED;
      end
      result.return_ttl  = snap.outer_ttl;
      result.icmp_length = (cc >= hl) ? 16'(cc - hl) : 16'd0;
      result.msg_type    = snap.type_seen;
      result.msg_code    = snap.code_seen;
      result.header_rest = snap.rest_word;
   end

endmodule

// File: src/icmp_echo_reply_classifier.sv
// top level: icmp echo reply classifier with request, response and csr ports
// response path: input register, then result register, which waits for a free result slot
// throughput: one packet byte per cycle, unless a last byte waits for a full result slot
// reset: synchronous, clears the byte counter, captured fields and both valid flags
// reset also sets expected_ident to 0, expected_seq to 1 and target_addr to 0
module icmp_echo_reply_classifier #(
   parameter int MAX_PACKET = 65535
) (
   input  logic        clock,
   input  logic        reset,
   // request channel: one packet byte per request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pkt_byte,
   input  logic        req_last_byte,
   // response channel: one verdict per packet
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [7:0]  rsp_return_ttl,
   output logic [15:0] rsp_icmp_length,
   output logic [7:0]  rsp_msg_type,
   output logic [7:0]  rsp_msg_code,
   output logic [31:0] rsp_header_rest,
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   iecr_pkg::result_type rsp_ff;

   // configuration
   iecr_pkg::cfg_type cfg_ff;

   iecr_pkg::snap_type   snap;
   iecr_pkg::result_type result;

   logic out_free;
   logic step;

   // result slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   // a middle byte always moves on, a last byte needs the result slot
   assign step     = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || step;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = (step && in_last_ff) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_pkt_byte;
         in_last_ff <= req_last_byte;
      end
      if (step && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   // csr writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_ident <= 16'd0;
         cfg_ff.expected_seq   <= 16'd1;
         cfg_ff.target_addr    <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            iecr_pkg::CSR_EXPECTED_IDENT: cfg_ff.expected_ident <= csr_data[15:0];
            iecr_pkg::CSR_EXPECTED_SEQ:   cfg_ff.expected_seq   <= csr_data[15:0];
            iecr_pkg::CSR_TARGET_ADDR:    cfg_ff.target_addr    <= csr_data;
            default: ;
         endcase
      end
   end

   // field capture, state clears after each last byte
   iecr_capture #(
      .MAX_PACKET (MAX_PACKET)
   ) u_capture (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .data_in (in_data_ff),
      .last_in (in_last_ff),
      .snap    (snap)
   );

   // verdict from the fields including the last byte
   iecr_classify u_classify (
      .snap   (snap),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_ff.verdict;
   assign rsp_return_ttl  = rsp_ff.return_ttl;
   assign rsp_icmp_length = rsp_ff.icmp_length;
   assign rsp_msg_type    = rsp_ff.msg_type;
   assign rsp_msg_code    = rsp_ff.msg_code;
   assign rsp_header_rest = rsp_ff.header_rest;

endmodule

// File: dv/tb_icmp_echo_reply_classifier.sv
// self-checking testbench for the icmp echo reply classifier, byte stream in, verdicts out
`timescale 1ns / 100ps

module tb_icmp_echo_reply_classifier;

   localparam int PKT_LIMIT = 65535;
   // index past the last register, writes to it must change nothing
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // how the stimulus shapes a frame
   typedef enum logic [1:0] {
      FRAME_REPLY,
      FRAME_ERROR,
      FRAME_NOISE
   } frame_kind_type;

   // one packet byte waiting for the request channel
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } wire_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_pkt_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_verdict;
   logic [7:0]  rsp_return_ttl;
   logic [15:0] rsp_icmp_length;
   logic [7:0]  rsp_msg_type;
   logic [7:0]  rsp_msg_code;
   logic [31:0] rsp_header_rest;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_data = 32'd0;

   // stimulus side
   wire_byte_type byte_backlog [$];
   logic [7:0]    frame_bytes [$];
   wire_byte_type next_byte;
   int unsigned bytes_pushed = 0;
   int unsigned bytes_taken = 0;
   int unsigned send_gap = 0;
   int unsigned sink_gap = 0;
   int unsigned hold_left = 0;
   int unsigned stall_requests = 0;
   int unsigned stall_served = 0;
   bit          calm_tail = 1'b0;
   bit          req_taken = 1'b0;

   // register values as the stimulus last wrote them, used to aim frames at a match
   logic [15:0] cur_ident = 16'd0;
   logic [15:0] cur_seq = 16'd1;
   logic [31:0] cur_target = 32'd0;

   // predictor state and the verdicts it still owes
   iecr_pkg::snap_type   pkt_state;
   iecr_pkg::cfg_type    echo_cfg;
   iecr_pkg::result_type pending_verdicts [$];
   int unsigned mismatches = 0;
   int unsigned responses_seen = 0;

   icmp_echo_reply_classifier #(
      .MAX_PACKET(PKT_LIMIT)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pkt_byte    (req_pkt_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_verdict     (rsp_verdict),
      .rsp_return_ttl  (rsp_return_ttl),
      .rsp_icmp_length (rsp_icmp_length),
      .rsp_msg_type    (rsp_msg_type),
      .rsp_msg_code    (rsp_msg_code),
      .rsp_header_rest (rsp_header_rest),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // one printed line per failure
   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t ns, response %0d: %s", $time, responses_seen, msg);
   endtask

   // predictor: absorbs one accepted byte, owes a verdict when the byte closes a packet
   task automatic classify_byte(input logic [7:0] b, input logic last);
      logic [15:0] pos;
      logic [15:0] rel;
      logic [16:0] count;
      logic [16:0] hlen;
      iecr_pkg::result_type verdict_out;
      // bytes past the packet limit are neither captured nor counted
      if (pkt_state.byte_count < 16'(PKT_LIMIT)) begin
         pos = pkt_state.byte_count;
         if (pos == iecr_pkg::POS_VER_IHL)
            pkt_state.ip_header_len = {b[3:0], 2'b00};
         if (pos == iecr_pkg::POS_TTL)
            pkt_state.outer_ttl = b;
         // no lower bound on header length, so icmp offsets may overlap the ip header
         if (pos >= 16'(pkt_state.ip_header_len)) begin
            rel = pos - 16'(pkt_state.ip_header_len);
            case (rel)
               iecr_pkg::REL_TYPE:      pkt_state.type_seen = b;
               iecr_pkg::REL_CODE:      pkt_state.code_seen = b;
               iecr_pkg::REL_REST_0:    pkt_state.rest_word[31:24] = b;
               iecr_pkg::REL_REST_1:    pkt_state.rest_word[23:16] = b;
               iecr_pkg::REL_REST_2:    pkt_state.rest_word[15:8] = b;
               iecr_pkg::REL_REST_3:    pkt_state.rest_word[7:0] = b;
               iecr_pkg::REL_IN_PROTO:  pkt_state.inner_proto = b;
               iecr_pkg::REL_IN_DST_0:  pkt_state.inner_dst[31:24] = b;
               iecr_pkg::REL_IN_DST_1:  pkt_state.inner_dst[23:16] = b;
               iecr_pkg::REL_IN_DST_2:  pkt_state.inner_dst[15:8] = b;
               iecr_pkg::REL_IN_DST_3:  pkt_state.inner_dst[7:0] = b;
               iecr_pkg::REL_IN_TYPE:   pkt_state.inner_type = b;
               iecr_pkg::REL_IN_IDENT0: pkt_state.inner_ident[15:8] = b;
               iecr_pkg::REL_IN_IDENT1: pkt_state.inner_ident[7:0] = b;
               default: ;
            endcase
         end
         pkt_state.byte_count = pkt_state.byte_count + 16'd1;
      end
      if (last) begin
         count = {1'b0, pkt_state.byte_count};
         hlen = 17'(pkt_state.ip_header_len);
         verdict_out.return_ttl = pkt_state.outer_ttl;
         verdict_out.icmp_length = (count >= hlen) ? 16'(count - hlen) : 16'd0;
         verdict_out.msg_type = pkt_state.type_seen;
         verdict_out.msg_code = pkt_state.code_seen;
         verdict_out.header_rest = pkt_state.rest_word;
         if (count < hlen + iecr_pkg::ICMP_MIN) begin
            verdict_out.verdict = iecr_pkg::VERDICT_SHORT;
         end else if (pkt_state.type_seen == iecr_pkg::TYPE_ECHO_REPLY) begin
            verdict_out.verdict = (pkt_state.rest_word[31:16] == echo_cfg.expected_ident &&
                                   pkt_state.rest_word[15:0] == echo_cfg.expected_seq)
                                  ? iecr_pkg::VERDICT_REPLY : iecr_pkg::VERDICT_UNRELATED;
         end else if (count < hlen + iecr_pkg::ERR_MIN) begin
            // error message cut before the embedded headers end
            verdict_out.verdict = iecr_pkg::VERDICT_UNRELATED;
         end else begin
            verdict_out.verdict = (pkt_state.inner_dst == echo_cfg.target_addr &&
                                   pkt_state.inner_proto == iecr_pkg::PROTO_ICMP &&
                                   pkt_state.inner_type == iecr_pkg::TYPE_ECHO_REQ &&
                                   pkt_state.inner_ident == echo_cfg.expected_ident)
                                  ? iecr_pkg::VERDICT_ERROR : iecr_pkg::VERDICT_UNRELATED;
         end
         pending_verdicts.push_back(verdict_out);
         pkt_state = '0;
      end
   endtask

   // monitor: everything is sampled at the rising edge, inputs settled since the falling one
   always @(posedge clock) begin
      iecr_pkg::result_type got;
      iecr_pkg::result_type want;
      if (reset) begin
         pkt_state = '0;
         echo_cfg.expected_ident = 16'd0;
         echo_cfg.expected_seq = 16'd1;
         echo_cfg.target_addr = 32'd0;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         // responses are checked before this edge's request can add a new verdict
         if (rsp_valid && rsp_ready) begin
            got.verdict = rsp_verdict;
            got.return_ttl = rsp_return_ttl;
            got.icmp_length = rsp_icmp_length;
            got.msg_type = rsp_msg_type;
            got.msg_code = rsp_msg_code;
            got.header_rest = rsp_header_rest;
            responses_seen++;
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("response with no packet closed, verdict %0d",
                                         got.verdict));
            end else begin
               want = pending_verdicts.pop_front();
               if (got.verdict !== want.verdict)
                  report_mismatch($sformatf("verdict got %0d want %0d",
                                            got.verdict, want.verdict));
               if (got.return_ttl !== want.return_ttl)
                  report_mismatch($sformatf("return_ttl got %0h want %0h",
                                            got.return_ttl, want.return_ttl));
               if (got.icmp_length !== want.icmp_length)
                  report_mismatch($sformatf("icmp_length got %0d want %0d",
                                            got.icmp_length, want.icmp_length));
               if (got.msg_type !== want.msg_type)
                  report_mismatch($sformatf("msg_type got %0h want %0h",
                                            got.msg_type, want.msg_type));
               if (got.msg_code !== want.msg_code)
                  report_mismatch($sformatf("msg_code got %0h want %0h",
                                            got.msg_code, want.msg_code));
               if (got.header_rest !== want.header_rest)
                  report_mismatch($sformatf("header_rest got %0h want %0h",
                                            got.header_rest, want.header_rest));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               iecr_pkg::CSR_EXPECTED_IDENT: echo_cfg.expected_ident = csr_data[15:0];
               iecr_pkg::CSR_EXPECTED_SEQ:   echo_cfg.expected_seq = csr_data[15:0];
               iecr_pkg::CSR_TARGET_ADDR:    echo_cfg.target_addr = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            classify_byte(req_pkt_byte, req_last_byte);
            bytes_taken++;
         end
      end
   end

   // request driver: holds each byte until taken, then maybe a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_backlog.size() > 0) begin
            next_byte = byte_backlog.pop_front();
            req_valid <= 1'b1;
            req_pkt_byte <= next_byte.data;
            req_last_byte <= next_byte.last;
            if (!calm_tail && $urandom_range(0, 15) == 0)
               send_gap = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response sink: random stall bursts, plus one long hold-off on request
   always @(negedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served = stall_requests;
         hold_left = 300;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap = sink_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm_tail && $urandom_range(0, 7) == 0)
            sink_gap = $urandom_range(1, 10);
      end
   end

   // writes a value msb first into the frame under construction, clipped at its end
   function automatic void place(input int unsigned at, input logic [31:0] value,
                                 input int unsigned width);
      int unsigned k;
      for (k = 0; k < width; k++)
         if (at + k < frame_bytes.size())
            frame_bytes[at + k] = value[8 * (width - 1 - k) +: 8];
   endfunction

   // builds one packet of random bytes with the fields of its kind laid in, and queues it;
   // a miss spoils exactly one of the compared fields
   task automatic compose_frame(input logic [3:0] ihl, input frame_kind_type kind,
                                input bit hit, input int unsigned len);
      int unsigned hl;
      int unsigned k;
      int unsigned pick;
      logic [7:0]  flip8;
      logic [15:0] flip16;
      logic [31:0] flip32;
      wire_byte_type entry;
      hl = 4 * ihl;
      pick = $urandom_range(0, 3);
      flip8 = hit ? 8'd0 : 8'($urandom_range(1, 255));
      flip16 = hit ? 16'd0 : 16'($urandom_range(1, 65535));
      flip32 = hit ? 32'd0 : 32'($urandom_range(1, 32'hFFFF_FFFF));
      frame_bytes = {};
      repeat (len) frame_bytes.push_back(8'($urandom));
      frame_bytes[0] = {frame_bytes[0][7:4], ihl};
      case (kind)
         FRAME_REPLY: begin
            place(hl, 32'(iecr_pkg::TYPE_ECHO_REPLY), 1);
            place(hl + 4, 32'(cur_ident ^ (pick[0] ? flip16 : 16'd0)), 2);
            place(hl + 6, 32'(cur_seq ^ (pick[0] ? 16'd0 : flip16)), 2);
         end
         FRAME_ERROR: begin
            // any nonzero type is treated as an error carrying our original request
            place(hl, $urandom_range(1, 255), 1);
            place(hl + 17, 32'(iecr_pkg::PROTO_ICMP ^ (pick == 0 ? flip8 : 8'd0)), 1);
            place(hl + 24, cur_target ^ (pick == 1 ? flip32 : 32'd0), 4);
            place(hl + 28, 32'(iecr_pkg::TYPE_ECHO_REQ ^ (pick == 2 ? flip8 : 8'd0)), 1);
            place(hl + 32, 32'(cur_ident ^ (pick == 3 ? flip16 : 16'd0)), 2);
         end
         default: ;
      endcase
      for (k = 0; k < len; k++) begin
         entry.data = frame_bytes[k];
         entry.last = (k == len - 1);
         byte_backlog.push_back(entry);
      end
      bytes_pushed += len;
   endtask

   // mostly well-formed replies and errors, some cut short, some pure noise
   task automatic random_frame();
      logic [3:0]  ihl;
      int unsigned hl;
      int unsigned sel;
      bit          hit;
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
      hl = 4 * ihl;
      sel = $urandom_range(0, 19);
      hit = ($urandom_range(0, 3) != 0);
      if (sel < 8)
         compose_frame(ihl, FRAME_REPLY, hit, hl + 8 + $urandom_range(0, 8));
      else if (sel < 14)
         compose_frame(ihl, FRAME_ERROR, hit, hl + 34 + $urandom_range(0, 4));
      else if (sel < 16)
         compose_frame(ihl, FRAME_ERROR, hit, hl + 8 + $urandom_range(0, 25));
      else if (sel < 18)
         compose_frame(ihl, FRAME_REPLY, hit, $urandom_range(1, hl + 7));
      else
         compose_frame(ihl, FRAME_NOISE, hit, $urandom_range(1, 60));
   endtask

   // csr write, only called while the block is idle
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         iecr_pkg::CSR_EXPECTED_IDENT: cur_ident = value[15:0];
         iecr_pkg::CSR_EXPECTED_SEQ:   cur_seq = value[15:0];
         iecr_pkg::CSR_TARGET_ADDR:    cur_target = value;
         default: ;
      endcase
   endtask

   // every queued byte taken and every verdict seen, then the pipeline's tail
   task automatic wait_drained();
      do @(negedge clock);
      while (bytes_taken != bytes_pushed || pending_verdicts.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // run sequence
   initial begin
      logic [1:0]  reg_order [4];
      logic [31:0] value;
      int unsigned phase;
      reg_order = '{iecr_pkg::CSR_EXPECTED_IDENT, iecr_pkg::CSR_EXPECTED_SEQ,
                    iecr_pkg::CSR_TARGET_ADDR, CSR_UNUSED};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values: own reply, mismatched reply, lone byte, one byte too short
      compose_frame(4'd5, FRAME_REPLY, 1'b1, 28);
      compose_frame(4'd5, FRAME_REPLY, 1'b0, 40);
      compose_frame(4'd5, FRAME_NOISE, 1'b0, 1);
      compose_frame(4'd5, FRAME_REPLY, 1'b1, 27);
      wait_drained();

      // all-ones registers, plus a write to the unused index
      write_csr(iecr_pkg::CSR_EXPECTED_IDENT, 32'hFFFF_FFFF);
      write_csr(iecr_pkg::CSR_EXPECTED_SEQ, 32'hFFFF_FFFF);
      write_csr(iecr_pkg::CSR_TARGET_ADDR, 32'hFFFF_FFFF);
      write_csr(CSR_UNUSED, $urandom);
      // error at its minimum length, a spoiled error, an error one byte short
      compose_frame(4'd5, FRAME_ERROR, 1'b1, 54);
      compose_frame(4'd5, FRAME_ERROR, 1'b0, 60);
      compose_frame(4'd5, FRAME_ERROR, 1'b1, 53);
      // longest header, and headers short enough to overlap the icmp fields
      compose_frame(4'd15, FRAME_ERROR, 1'b1, 100);
      compose_frame(4'd1, FRAME_REPLY, 1'b1, 12);
      compose_frame(4'd0, FRAME_REPLY, 1'b1, 8);
      compose_frame(4'd5, FRAME_REPLY, 1'b1, 28);
      wait_drained();

      // zero registers, with junk in the upper half of the 16-bit ones
      write_csr(iecr_pkg::CSR_EXPECTED_IDENT, 32'hFFFF_0000);
      write_csr(iecr_pkg::CSR_EXPECTED_SEQ, 32'hABCD_0000);
      write_csr(iecr_pkg::CSR_TARGET_ADDR, 32'd0);
      compose_frame(4'd5, FRAME_ERROR, 1'b1, 60);
      wait_drained();

      // random phases, each with fresh register values
      for (phase = 0; phase < 4; phase++) begin
         foreach (reg_order[r]) begin
            case ($urandom_range(0, 3))
               0:       value = 32'd0;
               1:       value = 32'hFFFF_FFFF;
               default: value = $urandom;
            endcase
            write_csr(reg_order[r], value);
         end
         if (phase == 1) begin
            // sink holds off while a burst of tiny packets backs up the block
            stall_requests++;
            repeat (10) compose_frame(4'd5, FRAME_NOISE, 1'b0, $urandom_range(1, 3));
         end
         if (phase == 3)
            calm_tail = 1'b1;
         repeat (2) random_frame();
         wait_drained();
      end

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #8000000;
      $display("status: fail");
      $finish;
   end

endmodule
